@@ hw/rtl/nutf_pkg.sv @@
// Package for the unit type finder: widths, reset value of the type register,
// and the state codes of the two scanners. No dependencies.
`default_nettype none
package nutf_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int TYPE_W      = 6;
  localparam int FIELD_W     = 24;
  localparam int LEN_W       = 32;
  localparam int END_W       = LEN_W + 1;
  localparam int ADDR_W      = 3;
  localparam int TDATA_W     = 56;

  localparam logic [TYPE_W-1:0] RESET_TYPE = 6'd62;

  // Config register word index
  localparam logic REG_TARGET_TYPE = 1'b0;

  // Length-prefix scanner phases
  localparam logic [1:0] PF_LENGTH = 2'd0;
  localparam logic [1:0] PF_HEADER = 2'd1;
  localparam logic [1:0] PF_BODY   = 2'd2;
  localparam logic [1:0] PF_STOP   = 2'd3;

  // Start-code scanner phases
  localparam logic [1:0] SC_SEEK   = 2'd0;
  localparam logic [1:0] SC_HEADER = 2'd1;
  localparam logic [1:0] SC_BODY   = 2'd2;
  localparam logic [1:0] SC_STOP   = 2'd3;

endpackage
`default_nettype wire

@@ hw/rtl/nal_unit_type_finder_top.sv @@
// Result path: the last byte item moves from the input register to the result
// register, which drives out_*. One result item per packet (on tlast).
// Throughput: one byte item per cycle unless a last item waits on stalled out_*.
// Timing is set by the single pass from the input register through both
// scanners into the result register (33-bit unit-end add and compare).
// Reset (sync, active low): target type 62, both scanners at packet start.
// Top level of the unit type finder; uses nutf_pkg.
`default_nettype none
module nal_unit_type_finder_top
  import nutf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [7:0] data_byte
  input  wire logic                  in_tlast,   // last_byte
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [TDATA_W-1:0]         out_tdata,  // [0] found, [24:1] unit_offset,
                                                 // [48:25] unit_size, [55:49] zero
  output logic                       out_tuser,  // framing_kind
  // config port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [ADDR_W-1:0]     cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  // config register
  logic [TYPE_W-1:0] target_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_TARGET_TYPE) ?
                      {{(32-TYPE_W){1'b0}}, target_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= RESET_TYPE;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_TARGET_TYPE) begin
      target_r <= cfg_pwdata[TYPE_W-1:0];
    end
  end

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_fire;
  logic       out_valid_r;

  // a non-last item never needs the result register
  assign s1_fire   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // scanner state
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [1:0]             pf_phase_r, pf_phase_nxt;
  logic [1:0]             pf_cnt_r, pf_cnt_nxt;
  logic [LEN_W-1:0]       pf_len_r, pf_len_nxt;
  logic [END_W-1:0]       pf_end_r, pf_end_nxt;
  logic                   pm_valid_r, pm_valid_nxt;
  logic [OFFSET_BITS-1:0] pm_off_r, pm_off_nxt;
  logic [FIELD_W-1:0]     pm_size_r, pm_size_nxt;
  logic [1:0]             sc_phase_r, sc_phase_nxt;
  logic [1:0]             zrun_r, zrun_nxt;
  logic [OFFSET_BITS-1:0] sc_start_r, sc_start_nxt;
  logic                   sc_tgt_r, sc_tgt_nxt;
  logic                   sm_valid_r, sm_valid_nxt;
  logic [OFFSET_BITS-1:0] sm_off_r, sm_off_nxt;
  logic [FIELD_W-1:0]     sm_size_r, sm_size_nxt;

  // combinational temporaries
  logic [OFFSET_BITS:0]   next_pos;
  logic [END_W-1:0]       next_ext;
  logic [7:0]             b;
  logic                   tgt;
  logic [LEN_W-1:0]       len_shift;
  logic                   code;
  logic [OFFSET_BITS-1:0] sc_size;
  logic [OFFSET_BITS-1:0] fin_size;
  logic                   fin_valid;
  logic [OFFSET_BITS-1:0] fin_off;
  logic [FIELD_W-1:0]     fin_sz;
  logic                   res_found;
  logic                   res_kind;
  logic [FIELD_W-1:0]     res_off;
  logic [FIELD_W-1:0]     res_size;

  always_comb begin
    next_pos  = {1'b0, pos_r} + {{OFFSET_BITS{1'b0}}, 1'b1};
    next_ext  = {{(END_W-OFFSET_BITS-1){1'b0}}, next_pos};
    b         = s1_byte_r;
    tgt       = (b[6:1] == target_r);
    len_shift = {pf_len_r[LEN_W-9:0], b};
    sc_size   = '0;
    fin_size  = '0;

    pos_nxt      = next_pos[OFFSET_BITS-1:0];
    pf_phase_nxt = pf_phase_r;
    pf_cnt_nxt   = pf_cnt_r;
    pf_len_nxt   = pf_len_r;
    pf_end_nxt   = pf_end_r;
    pm_valid_nxt = pm_valid_r;
    pm_off_nxt   = pm_off_r;
    pm_size_nxt  = pm_size_r;
    sc_phase_nxt = sc_phase_r;
    sc_start_nxt = sc_start_r;
    sc_tgt_nxt   = sc_tgt_r;
    sm_valid_nxt = sm_valid_r;
    sm_off_nxt   = sm_off_r;
    sm_size_nxt  = sm_size_r;

    // length-prefix scanner
    unique case (pf_phase_r)
      PF_LENGTH: begin
        pf_len_nxt = len_shift;
        if (pf_cnt_r == 2'd3) begin
          pf_cnt_nxt = 2'd0;
          if (len_shift == '0) begin
            pf_phase_nxt = PF_STOP;
          end else begin
            pf_end_nxt   = next_ext + {1'b0, len_shift};
            pf_phase_nxt = PF_HEADER;
          end
        end else begin
          pf_cnt_nxt = pf_cnt_r + 2'd1;
        end
      end
      PF_HEADER: begin
        if (tgt) begin
          pm_valid_nxt = 1'b1;
          pm_off_nxt   = pos_r;
          pm_size_nxt  = pf_len_r[FIELD_W-1:0];
          pf_phase_nxt = PF_STOP;
        end else begin
          pf_phase_nxt = (next_ext == pf_end_r) ? PF_LENGTH : PF_BODY;
        end
      end
      PF_BODY: begin
        if (next_ext == pf_end_r) begin
          pf_phase_nxt = PF_LENGTH;
        end
      end
      default: begin
      end
    endcase

    // start-code scanner; zero run saturates at three
    code = (b == 8'd1) && (zrun_r >= 2'd2);
    if (b == 8'd0) begin
      zrun_nxt = (zrun_r == 2'd3) ? 2'd3 : zrun_r + 2'd1;
    end else begin
      zrun_nxt = 2'd0;
    end

    if (sc_phase_nxt == SC_HEADER) begin
      sc_tgt_nxt   = tgt;
      sc_phase_nxt = SC_BODY;
    end
    if (code) begin
      if (sc_phase_nxt == SC_BODY) begin
        // unit ends where this start code's zero run began
        sc_size = pos_r - {{(OFFSET_BITS-2){1'b0}}, zrun_r} - sc_start_r;
        if (sc_size < 2) begin
          sc_phase_nxt = SC_STOP;
        end else if (sc_tgt_nxt) begin
          sm_valid_nxt = 1'b1;
          sm_off_nxt   = sc_start_r;
          sm_size_nxt  = sc_size[FIELD_W-1:0];
          sc_phase_nxt = SC_STOP;
        end
      end
      if (sc_phase_nxt == SC_SEEK || sc_phase_nxt == SC_BODY) begin
        sc_start_nxt = next_pos[OFFSET_BITS-1:0];
        sc_tgt_nxt   = 1'b0;
        sc_phase_nxt = SC_HEADER;
      end
    end

    // open start-code unit runs to the packet end
    fin_valid = sm_valid_nxt;
    fin_off   = sm_off_nxt;
    fin_sz    = sm_size_nxt;
    if (sc_phase_nxt == SC_BODY) begin
      fin_size = next_pos[OFFSET_BITS-1:0] - sc_start_nxt;
      if (fin_size >= 2 && sc_tgt_nxt) begin
        fin_valid = 1'b1;
        fin_off   = sc_start_nxt;
        fin_sz    = fin_size[FIELD_W-1:0];
      end
    end

    // prefix match counts only if its unit fits in the packet
    res_found = 1'b0;
    res_kind  = 1'b0;
    res_off   = '0;
    res_size  = '0;
    if (pm_valid_nxt && pf_end_nxt <= next_ext) begin
      res_found = 1'b1;
      res_off   = pm_off_nxt[FIELD_W-1:0];
      res_size  = pm_size_nxt;
    end else if (fin_valid) begin
      res_found = 1'b1;
      res_kind  = 1'b1;
      res_off   = fin_off[FIELD_W-1:0];
      res_size  = fin_sz;
    end

    if (s1_last_r) begin
      pos_nxt      = '0;
      pf_phase_nxt = PF_LENGTH;
      pf_cnt_nxt   = 2'd0;
      pf_len_nxt   = '0;
      pf_end_nxt   = '0;
      pm_valid_nxt = 1'b0;
      sc_phase_nxt = SC_SEEK;
      zrun_nxt     = 2'd0;
      sc_start_nxt = '0;
      sc_tgt_nxt   = 1'b0;
      sm_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      pf_phase_r <= PF_LENGTH;
      pf_cnt_r   <= 2'd0;
      pf_len_r   <= '0;
      pf_end_r   <= '0;
      pm_valid_r <= 1'b0;
      sc_phase_r <= SC_SEEK;
      zrun_r     <= 2'd0;
      sc_start_r <= '0;
      sc_tgt_r   <= 1'b0;
      sm_valid_r <= 1'b0;
    end else if (s1_fire) begin
      pos_r      <= pos_nxt;
      pf_phase_r <= pf_phase_nxt;
      pf_cnt_r   <= pf_cnt_nxt;
      pf_len_r   <= pf_len_nxt;
      pf_end_r   <= pf_end_nxt;
      pm_valid_r <= pm_valid_nxt;
      sc_phase_r <= sc_phase_nxt;
      zrun_r     <= zrun_nxt;
      sc_start_r <= sc_start_nxt;
      sc_tgt_r   <= sc_tgt_nxt;
      sm_valid_r <= sm_valid_nxt;
    end
  end

  // match payloads only matter while their valid bit is set
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      pm_off_r  <= pm_off_nxt;
      pm_size_r <= pm_size_nxt;
      sm_off_r  <= sm_off_nxt;
      sm_size_r <= sm_size_nxt;
    end
  end

  // result register
  logic [TDATA_W-1:0] out_data_r;
  logic               out_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_data_r <= {{(TDATA_W-2*FIELD_W-1){1'b0}}, res_size, res_off, res_found};
      out_kind_r <= res_kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule
`default_nettype wire

@@ hw/rtl/nutf_checker.sv @@
// Port-level checks for the unit type finder, bound to the top level.
// Uses nutf_pkg for widths and the reset type value.
`default_nettype none
module nutf_checker
  import nutf_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tready,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [TDATA_W-1:0] out_tdata,
  input wire logic               out_tuser,
  input wire logic [ADDR_W-1:0]  cfg_paddr,
  input wire logic [31:0]        cfg_prdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // no match means every field is zero
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> !out_tuser && out_tdata[TDATA_W-1:1] == '0)
    else $error("empty result carries nonzero fields");

  // input stage empty right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_tready)
    else $error("input not ready after reset");

  // type register comes up at its reset value
  a_reset_type: assert property (@(posedge clk)
    rst_n && $past(!rst_n) && cfg_paddr[2] == REG_TARGET_TYPE |->
      cfg_prdata == {{(32-TYPE_W){1'b0}}, RESET_TYPE})
    else $error("target type register not at reset value");

endmodule

bind nal_unit_type_finder_top nutf_checker u_nutf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_paddr  (cfg_paddr),
  .cfg_prdata (cfg_prdata)
);
`default_nettype wire
